// File: design/icsp_pkg.sv
// Shared types, constants and frame tables for the ICSP command engine.
package icsp_pkg;

  // Wait counter, configuration and APB widths
  localparam int unsigned WAIT_BITS = 24;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  // Configuration register indexes
  typedef enum logic {
    REG_PROG_WAIT  = 1'b0,
    REG_ERASE_WAIT = 1'b1
  } reg_idx_e;

  localparam logic [CFG_W-1:0] PROG_WAIT_RST  = 24'd45000;
  localparam logic [CFG_W-1:0] ERASE_WAIT_RST = 24'd80000;

  // Command codes
  localparam logic [3:0] CMD_LD_CFG     = 4'd0;
  localparam logic [3:0] CMD_LD_PROG    = 4'd1;
  localparam logic [3:0] CMD_LD_USER    = 4'd2;
  localparam logic [3:0] CMD_RD_PROG    = 4'd3;
  localparam logic [3:0] CMD_RD_USER    = 4'd4;
  localparam logic [3:0] CMD_INC_ADDR   = 4'd5;
  localparam logic [3:0] CMD_BEGIN      = 4'd6;
  localparam logic [3:0] CMD_ERASE1     = 4'd7;
  localparam logic [3:0] CMD_ERASE2     = 4'd8;
  localparam logic [3:0] CMD_PROT_ERASE = 4'd9;

  // Frame lengths and read frame landmarks, in half periods
  localparam logic [5:0] CMD_HALVES   = 6'd12;
  localparam logic [5:0] DATA_HALVES  = 6'd32;
  localparam logic [5:0] READ_HALVES  = 6'd32;
  localparam logic [5:0] READ_RELEASE = 6'd2;
  localparam logic [5:0] READ_RETAKE  = 6'd30;
  localparam logic [3:0] READ_BITS    = 4'd14;

  // Frame kinds of the sequencer
  typedef enum logic [2:0] {
    KIND_IDLE  = 3'd0,
    KIND_CMD   = 3'd1,
    KIND_DATA  = 3'd2,
    KIND_READ  = 3'd3,
    KIND_WAITP = 3'd4,
    KIND_WAITE = 3'd5,
    KIND_END   = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] arg;
  } op_t;

  // Input and result items
  typedef struct packed {
    logic        req_type;
    logic [3:0]  command_code;
    logic [13:0] write_word;
    logic        data_line_in;
  } in_item_t;

  typedef struct packed {
    logic        clock_level;
    logic        data_level;
    logic        data_drive;
    logic        busy_res;
    logic [13:0] read_word;
    logic        read_valid;
    logic        cmd_rejected;
  } out_item_t;

  // Configured wait lengths
  typedef struct packed {
    logic [CFG_W-1:0] program_wait;
    logic [CFG_W-1:0] erase_wait;
  } cfg_t;

  // Protected erase sequence
  localparam int unsigned PE_STEPS = 16;

  localparam kind_e PE_KIND [PE_STEPS] = '{
    KIND_CMD, KIND_DATA, KIND_CMD, KIND_CMD, KIND_CMD, KIND_CMD, KIND_CMD, KIND_CMD,
    KIND_CMD, KIND_CMD, KIND_CMD, KIND_CMD, KIND_WAITP, KIND_WAITE, KIND_CMD, KIND_CMD
  };

  localparam logic [15:0] PE_ARG [PE_STEPS] = '{
    16'h0000, 16'h7FFE, 16'h0006, 16'h0006, 16'h0006, 16'h0006, 16'h0006, 16'h0006,
    16'h0006, 16'h0001, 16'h0007, 16'h0008, 16'h0000, 16'h0000, 16'h0001, 16'h0007
  };

  // 6-bit opcode sent first for each plain command
  function automatic logic [15:0] lead_code(logic [3:0] cmd);
    logic [15:0] c;
    unique case (cmd)
      CMD_LD_CFG:   c = 16'h0000;
      CMD_LD_PROG:  c = 16'h0002;
      CMD_LD_USER:  c = 16'h0003;
      CMD_RD_PROG:  c = 16'h0004;
      CMD_RD_USER:  c = 16'h0005;
      CMD_INC_ADDR: c = 16'h0006;
      CMD_BEGIN:    c = 16'h0008;
      CMD_ERASE1:   c = 16'h0001;
      CMD_ERASE2:   c = 16'h0007;
      default:      c = 16'h0000;
    endcase
    return c;
  endfunction

  // Frame to run at a given step of a command
  function automatic op_t op_at(logic [3:0] cmd, logic [4:0] step, logic [13:0] word);
    op_t o;
    o.kind = KIND_END;
    o.arg  = '0;
    if (cmd == CMD_PROT_ERASE) begin
      if (!step[4]) begin
        o.kind = PE_KIND[step[3:0]];
        o.arg  = PE_ARG[step[3:0]];
      end
    end else if (cmd < CMD_PROT_ERASE) begin
      if (step == 5'd0) begin
        o.kind = KIND_CMD;
        o.arg  = lead_code(cmd);
      end else if (step == 5'd1) begin
        if (cmd <= CMD_LD_USER) begin
          o.kind = KIND_DATA;
          o.arg  = {1'b0, word, 1'b0};
        end else if (cmd == CMD_RD_PROG || cmd == CMD_RD_USER) begin
          o.kind = KIND_READ;
        end else if (cmd == CMD_BEGIN) begin
          o.kind = KIND_WAITP;
        end
      end
    end
    return o;
  endfunction

endpackage

// File: design/icsp_serial_command_engine.sv
// Top level of the ICSP serial command engine: item registers, sequencer and APB block.
//
// Each input item is either a command request or one half-clock tick of the
// programming link, and each gives exactly one result item with the pin
// levels, busy flag, last read word and status flags. An accepted item is
// worked by the frame sequencer while it is held in the input register, and
// its result is loaded into the output register on the edge at which the
// item advances, which waits while a stalled result is still held there:
// an item passes the input register and then the output register, and one
// item a cycle is sustained while out_ready_i is high. The sequencer's state
// update is the only loop. Wait lengths are set through the APB port
// (program wait at 0x0, erase wait at 0x4) and should be written only while
// no item is in flight.
module icsp_serial_command_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  icsp_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output icsp_pkg::out_item_t          out_item_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [icsp_pkg::ADDR_W-1:0]  paddr,
  input  logic [icsp_pkg::DATA_W-1:0]  pwdata,
  output logic [icsp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  icsp_pkg::cfg_t      cfg;
  icsp_pkg::in_item_t  in_item_q;
  icsp_pkg::out_item_t out_item_q, res;
  logic                in_valid_q, out_valid_q, adv;

  icsp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Work the held item when the output register can take its result
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  icsp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_en_i (adv),
    .item_i    (in_item_q),
    .res_o     (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_item_q <= in_item_i;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_item_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: design/icsp_cfg_regs.sv
// APB register block holding the two wait lengths.
module icsp_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [icsp_pkg::ADDR_W-1:0]       paddr,
  input  logic [icsp_pkg::DATA_W-1:0]       pwdata,
  output logic [icsp_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  output icsp_pkg::cfg_t                    cfg_o
);

  logic [icsp_pkg::CFG_W-1:0] prog_wait_q;
  logic [icsp_pkg::CFG_W-1:0] erase_wait_q;
  logic                       wr_en;
  icsp_pkg::reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = icsp_pkg::reg_idx_e'(paddr[2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_wait_q  <= icsp_pkg::PROG_WAIT_RST;
      erase_wait_q <= icsp_pkg::ERASE_WAIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        icsp_pkg::REG_PROG_WAIT:  prog_wait_q  <= pwdata[icsp_pkg::CFG_W-1:0];
        icsp_pkg::REG_ERASE_WAIT: erase_wait_q <= pwdata[icsp_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      icsp_pkg::REG_PROG_WAIT:
        prdata = {{(icsp_pkg::DATA_W-icsp_pkg::CFG_W){1'b0}}, prog_wait_q};
      icsp_pkg::REG_ERASE_WAIT:
        prdata = {{(icsp_pkg::DATA_W-icsp_pkg::CFG_W){1'b0}}, erase_wait_q};
      default: prdata = '0;
    endcase
  end

  assign cfg_o.program_wait = prog_wait_q;
  assign cfg_o.erase_wait   = erase_wait_q;

endmodule

// File: design/icsp_core.sv
// Frame sequencer: pin state, shift registers and wait counter, one item per enabled cycle.
module icsp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  icsp_pkg::cfg_t       cfg_i,
  input  logic                 step_en_i,
  input  icsp_pkg::in_item_t   item_i,
  output icsp_pkg::out_item_t  res_o
);

  icsp_pkg::kind_e                 kind_q, kind_d;
  logic [5:0]                      half_q, half_d, half_inc;
  logic [15:0]                     tx_q, tx_d;
  logic [13:0]                     rx_q, rx_d;
  logic [3:0]                      idx_q, idx_d;
  logic [icsp_pkg::WAIT_BITS-1:0]  wc_q, wc_d, wait_ld;
  logic [3:0]                      seq_q, seq_d;
  logic                            clk_q, clk_d, dat_q, dat_d, drv_q, drv_d;
  logic [3:0]                      cmd_q, cmd_d, sel_cmd;
  logic [13:0]                     word_q, word_d, sel_word;
  logic [13:0]                     rlatch_q, rlatch_d;
  logic                            rd_valid, rejected, start_req;
  logic [4:0]                      st;
  icsp_pkg::op_t                   op;

  // Load value of a wait frame, sized to the counter width
  function automatic logic [icsp_pkg::WAIT_BITS-1:0] wait_len(icsp_pkg::kind_e k,
                                                              icsp_pkg::cfg_t c);
    return (k == icsp_pkg::KIND_WAITP) ? icsp_pkg::WAIT_BITS'(c.program_wait)
                                       : icsp_pkg::WAIT_BITS'(c.erase_wait);
  endfunction

  function automatic logic zero_wait(icsp_pkg::op_t o, icsp_pkg::cfg_t c);
    return (o.kind == icsp_pkg::KIND_WAITP || o.kind == icsp_pkg::KIND_WAITE) &&
           (wait_len(o.kind, c) == '0);
  endfunction

  assign half_inc = half_q + 6'd1;

  // Next state for one item
  always_comb begin
    kind_d    = kind_q;
    half_d    = half_q;
    tx_d      = tx_q;
    rx_d      = rx_q;
    idx_d     = idx_q;
    wc_d      = wc_q;
    seq_d     = seq_q;
    clk_d     = clk_q;
    dat_d     = dat_q;
    drv_d     = drv_q;
    cmd_d     = cmd_q;
    word_d    = word_q;
    rlatch_d  = rlatch_q;
    rd_valid  = 1'b0;
    rejected  = 1'b0;
    start_req = 1'b0;
    st        = {1'b0, seq_q} + 5'd1;
    sel_cmd   = cmd_q;
    sel_word  = word_q;
    op        = '{kind: icsp_pkg::KIND_END, arg: '0};
    wait_ld   = '0;

    if (item_i.req_type) begin
      // new command: only taken while idle and with a known code
      if (kind_q != icsp_pkg::KIND_IDLE || item_i.command_code > icsp_pkg::CMD_PROT_ERASE) begin
        rejected = 1'b1;
      end else begin
        cmd_d     = item_i.command_code;
        word_d    = item_i.write_word;
        sel_cmd   = item_i.command_code;
        sel_word  = item_i.write_word;
        start_req = 1'b1;
        st        = 5'd0;
      end
    end else begin
      unique case (kind_q)
        icsp_pkg::KIND_CMD, icsp_pkg::KIND_DATA: begin
          clk_d = ~clk_q;
          if (!half_q[0]) begin
            dat_d = tx_q[0];
            tx_d  = {1'b0, tx_q[15:1]};
          end
          half_d = half_inc;
          if (half_inc >= ((kind_q == icsp_pkg::KIND_CMD) ? icsp_pkg::CMD_HALVES
                                                          : icsp_pkg::DATA_HALVES)) begin
            start_req = 1'b1;
          end
        end
        icsp_pkg::KIND_READ: begin
          clk_d = ~clk_q;
          if (half_q == icsp_pkg::READ_RELEASE) begin
            drv_d = 1'b0;
          end else if (half_q > icsp_pkg::READ_RELEASE && half_q < icsp_pkg::READ_RETAKE &&
                       half_q[0]) begin
            if (idx_q < icsp_pkg::READ_BITS) begin
              rx_d  = rx_q | (14'(item_i.data_line_in) << idx_q);
              idx_d = idx_q + 4'd1;
            end
          end else if (half_q == icsp_pkg::READ_RETAKE) begin
            drv_d = 1'b1;
          end
          half_d = half_inc;
          if (half_inc >= icsp_pkg::READ_HALVES) begin
            rlatch_d  = rx_d;
            rd_valid  = 1'b1;
            start_req = 1'b1;
          end
        end
        icsp_pkg::KIND_WAITP, icsp_pkg::KIND_WAITE: begin
          if (wc_q != '0) wc_d = wc_q - icsp_pkg::WAIT_BITS'(1);
          if (wc_d == '0) start_req = 1'b1;
        end
        default: ;
      endcase
    end

    // Start the next frame, stepping over waits of zero length
    if (start_req) begin
      op = icsp_pkg::op_at(sel_cmd, st, sel_word);
      if (zero_wait(op, cfg_i)) begin
        st = st + 5'd1;
        op = icsp_pkg::op_at(sel_cmd, st, sel_word);
        if (zero_wait(op, cfg_i)) begin
          st = st + 5'd1;
          op = icsp_pkg::op_at(sel_cmd, st, sel_word);
        end
      end
      wait_ld = wait_len(op.kind, cfg_i);
      half_d  = '0;
      if (op.kind == icsp_pkg::KIND_END) begin
        kind_d = icsp_pkg::KIND_IDLE;
        seq_d  = '0;
      end else begin
        unique case (op.kind)
          icsp_pkg::KIND_CMD, icsp_pkg::KIND_DATA: tx_d = op.arg;
          icsp_pkg::KIND_READ: begin
            rx_d  = '0;
            idx_d = '0;
          end
          icsp_pkg::KIND_WAITP, icsp_pkg::KIND_WAITE: wc_d = wait_ld;
          default: ;
        endcase
        kind_d = op.kind;
        seq_d  = st[3:0];
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= icsp_pkg::KIND_IDLE;
      half_q   <= '0;
      tx_q     <= '0;
      rx_q     <= '0;
      idx_q    <= '0;
      wc_q     <= '0;
      seq_q    <= '0;
      clk_q    <= 1'b0;
      dat_q    <= 1'b0;
      drv_q    <= 1'b1;
      cmd_q    <= '0;
      word_q   <= '0;
      rlatch_q <= '0;
    end else if (step_en_i) begin
      kind_q   <= kind_d;
      half_q   <= half_d;
      tx_q     <= tx_d;
      rx_q     <= rx_d;
      idx_q    <= idx_d;
      wc_q     <= wc_d;
      seq_q    <= seq_d;
      clk_q    <= clk_d;
      dat_q    <= dat_d;
      drv_q    <= drv_d;
      cmd_q    <= cmd_d;
      word_q   <= word_d;
      rlatch_q <= rlatch_d;
    end
  end

  // Result item
  assign res_o.clock_level  = clk_d;
  assign res_o.data_level   = dat_d;
  assign res_o.data_drive   = drv_d;
  assign res_o.busy_res     = (kind_d != icsp_pkg::KIND_IDLE);
  assign res_o.read_word    = rlatch_d;
  assign res_o.read_valid   = rd_valid;
  assign res_o.cmd_rejected = rejected;

endmodule

// File: design/icsp_checker.sv
// Port-level checks for the ICSP command engine, bound to the top level.
module icsp_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input icsp_pkg::out_item_t  out_item_o,
  input logic                 pready
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // A completed read and a dropped request never share one item
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.read_valid && out_item_o.cmd_rejected))
    else $error("read_valid and cmd_rejected both set");

  // Idle link: clock low, data line driven
  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.busy_res |-> out_item_o.data_drive && !out_item_o.clock_level)
    else $error("idle link with clock high or data released");

  // A read frame is always the last frame of its command
  a_read_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.read_valid |-> !out_item_o.busy_res)
    else $error("busy after read completion");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind icsp_serial_command_engine icsp_checker u_icsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o),
  .pready      (pready)
);

// File: verif/tb_icsp_serial_command_engine.sv
// Self-checking testbench for the ICSP serial command engine: predictor, item driver and checker.
module tb_icsp_serial_command_engine;

  // Opcodes and words seen on the link
  localparam logic [15:0] OP_LOAD_CFG  = 16'h0000;
  localparam logic [15:0] OP_LOAD_PROG = 16'h0002;
  localparam logic [15:0] OP_LOAD_USER = 16'h0003;
  localparam logic [15:0] OP_READ_PROG = 16'h0004;
  localparam logic [15:0] OP_READ_USER = 16'h0005;
  localparam logic [15:0] OP_INC_ADDR  = 16'h0006;
  localparam logic [15:0] OP_BEGIN     = 16'h0008;
  localparam logic [15:0] OP_ERASE1    = 16'h0001;
  localparam logic [15:0] OP_ERASE2    = 16'h0007;
  localparam logic [13:0] WORD_ONES    = 14'h3FFF;
  localparam int          WORD_BITS    = 14;

  // Frame landmarks in half periods
  localparam logic [5:0] HALVES_CMD   = 6'd12;
  localparam logic [5:0] HALVES_DATA  = 6'd32;
  localparam logic [5:0] HALVES_READ  = 6'd32;
  localparam logic [5:0] HALF_RELEASE = 6'd2;
  localparam logic [5:0] HALF_RETAKE  = 6'd30;

  // Steps of the protected erase sequence
  localparam int ERASE_DATA_STEP  = 1;
  localparam int ERASE_LAST_INC   = 8;
  localparam int ERASE_PROG_WAIT  = 12;
  localparam int ERASE_ERASE_WAIT = 13;
  localparam int ERASE_STEPS      = 16;

  localparam logic [23:0] RESET_PROG_WAIT  = 24'd45000;
  localparam logic [23:0] RESET_ERASE_WAIT = 24'd80000;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int TAIL_CYCLES    = 8;
  localparam int PHASE_ITEMS    = 8;
  localparam int RANDOM_PHASES  = 3;

  // Level sources for read frames
  localparam int LEVEL_LOW  = 0;
  localparam int LEVEL_HIGH = 1;
  localparam int LEVEL_RAND = 2;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  icsp_pkg::in_item_t            in_item;
  logic                          out_valid;
  logic                          out_ready;
  icsp_pkg::out_item_t           out_item;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [icsp_pkg::ADDR_W-1:0]   paddr;
  logic [icsp_pkg::DATA_W-1:0]   pwdata;
  logic [icsp_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  logic                  idling_on = 1'b1;
  int                    mismatches = 0;
  int                    cycle_count;
  icsp_pkg::out_item_t   pin_results_q[$];

  // Predictor state
  logic [23:0]       cfg_prog_wait;
  logic [23:0]       cfg_erase_wait;
  logic [5:0]        ph_count;
  logic [15:0]       shift_out;
  icsp_pkg::kind_e   cur_kind;
  logic [13:0]       rx_word;
  logic [3:0]        rx_bits;
  logic [23:0]       ticks_left;
  int                cur_step;
  logic              pin_clk;
  logic              pin_dat;
  logic              pin_drv;
  logic [3:0]        cur_cmd;
  logic [13:0]       load_word;
  logic [13:0]       last_read;

  icsp_serial_command_engine i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Timeout
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void engine_reset();
    cfg_prog_wait  = RESET_PROG_WAIT;
    cfg_erase_wait = RESET_ERASE_WAIT;
    ph_count   = '0;
    shift_out  = '0;
    cur_kind   = icsp_pkg::KIND_IDLE;
    rx_word    = '0;
    rx_bits    = '0;
    ticks_left = '0;
    cur_step   = 0;
    pin_clk    = 1'b0;
    pin_dat    = 1'b0;
    pin_drv    = 1'b1;
    cur_cmd    = '0;
    load_word  = '0;
    last_read  = '0;
  endfunction

  function automatic logic [15:0] opcode_of(logic [3:0] cmd);
    case (cmd)
      icsp_pkg::CMD_LD_PROG:  return OP_LOAD_PROG;
      icsp_pkg::CMD_LD_USER:  return OP_LOAD_USER;
      icsp_pkg::CMD_RD_PROG:  return OP_READ_PROG;
      icsp_pkg::CMD_RD_USER:  return OP_READ_USER;
      icsp_pkg::CMD_INC_ADDR: return OP_INC_ADDR;
      icsp_pkg::CMD_BEGIN:    return OP_BEGIN;
      icsp_pkg::CMD_ERASE1:   return OP_ERASE1;
      icsp_pkg::CMD_ERASE2:   return OP_ERASE2;
      default:                return OP_LOAD_CFG;
    endcase
  endfunction

  // Frame kind and payload at a step of the active command
  function automatic void frame_for(input int step, output icsp_pkg::kind_e k,
                                    output logic [15:0] a);
    a = '0;
    k = icsp_pkg::KIND_END;
    if (cur_cmd == icsp_pkg::CMD_PROT_ERASE) begin
      k = icsp_pkg::KIND_CMD;
      if (step == 0) a = OP_LOAD_CFG;
      else if (step == ERASE_DATA_STEP) begin
        k = icsp_pkg::KIND_DATA;
        a = {1'b0, WORD_ONES, 1'b0};
      end else if (step <= ERASE_LAST_INC) a = OP_INC_ADDR;
      else if (step == ERASE_LAST_INC + 1 || step == ERASE_ERASE_WAIT + 1) a = OP_ERASE1;
      else if (step == ERASE_LAST_INC + 2 || step == ERASE_ERASE_WAIT + 2) a = OP_ERASE2;
      else if (step == ERASE_LAST_INC + 3) a = OP_BEGIN;
      else if (step == ERASE_PROG_WAIT) k = icsp_pkg::KIND_WAITP;
      else if (step == ERASE_ERASE_WAIT) k = icsp_pkg::KIND_WAITE;
      else k = icsp_pkg::KIND_END;
      if (step >= ERASE_STEPS) k = icsp_pkg::KIND_END;
    end else if (cur_cmd <= icsp_pkg::CMD_ERASE2) begin
      if (step == 0) begin
        k = icsp_pkg::KIND_CMD;
        a = opcode_of(cur_cmd);
      end else if (step == 1) begin
        if (cur_cmd <= icsp_pkg::CMD_LD_USER) begin
          k = icsp_pkg::KIND_DATA;
          a = {1'b0, load_word, 1'b0};
        end else if (cur_cmd == icsp_pkg::CMD_RD_PROG || cur_cmd == icsp_pkg::CMD_RD_USER) begin
          k = icsp_pkg::KIND_READ;
        end else if (cur_cmd == icsp_pkg::CMD_BEGIN) begin
          k = icsp_pkg::KIND_WAITP;
        end
      end
    end
  endfunction

  // Load the next frame; waits of zero length are passed over
  function automatic void start_frame(input int step);
    icsp_pkg::kind_e k;
    logic [15:0]     a;
    logic            done;
    done = 1'b0;
    while (!done) begin
      frame_for(step, k, a);
      ph_count = '0;
      if (k == icsp_pkg::KIND_END) begin
        cur_kind = icsp_pkg::KIND_IDLE;
        cur_step = 0;
        done = 1'b1;
      end else begin
        if (k == icsp_pkg::KIND_CMD || k == icsp_pkg::KIND_DATA) begin
          shift_out = a;
        end else if (k == icsp_pkg::KIND_READ) begin
          rx_word = '0;
          rx_bits = '0;
        end else begin
          ticks_left = (k == icsp_pkg::KIND_WAITP) ? cfg_prog_wait : cfg_erase_wait;
        end
        if ((k == icsp_pkg::KIND_WAITP || k == icsp_pkg::KIND_WAITE) && ticks_left == '0) begin
          step++;
        end else begin
          cur_kind = k;
          cur_step = step;
          done = 1'b1;
        end
      end
    end
  endfunction

  // Pin levels and flags after one accepted item
  function automatic icsp_pkg::out_item_t pin_levels_after(icsp_pkg::in_item_t it);
    icsp_pkg::out_item_t r;
    logic                rejected;
    logic                read_done;
    rejected  = 1'b0;
    read_done = 1'b0;
    if (it.req_type) begin
      if (cur_kind != icsp_pkg::KIND_IDLE || it.command_code > icsp_pkg::CMD_PROT_ERASE) begin
        rejected = 1'b1;
      end else begin
        cur_cmd   = it.command_code;
        load_word = it.write_word;
        start_frame(0);
      end
    end else if (cur_kind == icsp_pkg::KIND_CMD || cur_kind == icsp_pkg::KIND_DATA) begin
      pin_clk = ~pin_clk;
      if (!ph_count[0]) begin
        pin_dat   = shift_out[0];
        shift_out = shift_out >> 1;
      end
      ph_count++;
      if (ph_count >= ((cur_kind == icsp_pkg::KIND_CMD) ? HALVES_CMD : HALVES_DATA))
        start_frame(cur_step + 1);
    end else if (cur_kind == icsp_pkg::KIND_READ) begin
      pin_clk = ~pin_clk;
      if (ph_count == HALF_RELEASE) begin
        pin_drv = 1'b0;
      end else if (ph_count > HALF_RELEASE && ph_count < HALF_RETAKE && ph_count[0]) begin
        if (rx_bits < WORD_BITS) begin
          rx_word[rx_bits] = it.data_line_in;
          rx_bits++;
        end
      end else if (ph_count == HALF_RETAKE) begin
        pin_drv = 1'b1;
      end
      ph_count++;
      if (ph_count >= HALVES_READ) begin
        last_read = rx_word;
        read_done = 1'b1;
        start_frame(cur_step + 1);
      end
    end else if (cur_kind == icsp_pkg::KIND_WAITP || cur_kind == icsp_pkg::KIND_WAITE) begin
      if (ticks_left > 0) ticks_left--;
      if (ticks_left == '0) start_frame(cur_step + 1);
    end
    r.clock_level  = pin_clk;
    r.data_level   = pin_dat;
    r.data_drive   = pin_drv;
    r.busy_res     = (cur_kind != icsp_pkg::KIND_IDLE);
    r.read_word    = last_read;
    r.read_valid   = read_done;
    r.cmd_rejected = rejected;
    return r;
  endfunction

  // ---------------------------------------------------------------- idling

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (!idling_on) return 0;
    if ($urandom_range(0, 99) < 55) return 0;
    return idle_length();
  endfunction

  // Result side stalls
  initial begin : drive_out_ready
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!idling_on) begin
        hold = 0;
        out_ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
        out_ready <= 1'b1;
      end else begin
        hold = idle_length() - 1;
        out_ready <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    icsp_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pin_results_q.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got %h", $time, out_item);
        mismatches++;
      end else begin
        want = pin_results_q.pop_front();
        check_field("clock_level", 32'(want.clock_level), 32'(out_item.clock_level));
        check_field("data_level", 32'(want.data_level), 32'(out_item.data_level));
        check_field("data_drive", 32'(want.data_drive), 32'(out_item.data_drive));
        check_field("busy_res", 32'(want.busy_res), 32'(out_item.busy_res));
        check_field("read_word", 32'(want.read_word), 32'(out_item.read_word));
        check_field("read_valid", 32'(want.read_valid), 32'(out_item.read_valid));
        check_field("cmd_rejected", 32'(want.cmd_rejected), 32'(out_item.cmd_rejected));
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input icsp_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    pin_results_q.push_back(pin_levels_after(it));
  endtask

  task automatic send_tick(input logic level);
    icsp_pkg::in_item_t it;
    it.req_type     = 1'b0;
    it.command_code = 4'($urandom_range(0, 15));
    it.write_word   = 14'($urandom_range(0, 16383));
    it.data_line_in = level;
    send_item(it);
  endtask

  task automatic send_request(input logic [3:0] code, input logic [13:0] word);
    icsp_pkg::in_item_t it;
    it.req_type     = 1'b1;
    it.command_code = code;
    it.write_word   = word;
    it.data_line_in = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  function automatic logic pick_level(int source);
    if (source == LEVEL_RAND) return 1'($urandom_range(0, 1));
    return (source == LEVEL_HIGH);
  endfunction

  task automatic run_to_idle(input int source);
    while (cur_kind != icsp_pkg::KIND_IDLE) send_tick(pick_level(source));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pin_results_q.size() != 0);
  endtask

  task automatic reg_write(input icsp_pkg::reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == icsp_pkg::REG_PROG_WAIT) cfg_prog_wait = value[23:0];
    else cfg_erase_wait = value[23:0];
    @(posedge clk);
  endtask

  task automatic reg_check(input icsp_pkg::reg_idx_e idx);
    logic [31:0] want;
    want = {8'h00, (idx == icsp_pkg::REG_PROG_WAIT) ? cfg_prog_wait : cfg_erase_wait};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    reg_check(icsp_pkg::REG_PROG_WAIT);
    reg_check(icsp_pkg::REG_ERASE_WAIT);
  endtask

  // Ticks while idle leave the pins alone
  task automatic test_idle_ticks();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();
  endtask

  // Codes past protected erase are dropped
  task automatic test_bad_codes();
    for (int c = icsp_pkg::CMD_PROT_ERASE + 1; c < 16; c++)
      send_request(4'(c), 14'($urandom_range(0, 16383)));
    settle();
  endtask

  // Upper bits are masked off; then zero waits
  task automatic test_config_limits();
    reg_write(icsp_pkg::REG_PROG_WAIT, 32'hFFFF_FFFF);
    reg_write(icsp_pkg::REG_ERASE_WAIT, 32'hFFFF_FFFF);
    reg_check(icsp_pkg::REG_PROG_WAIT);
    reg_check(icsp_pkg::REG_ERASE_WAIT);
    reg_write(icsp_pkg::REG_PROG_WAIT, 32'h0);
    reg_write(icsp_pkg::REG_ERASE_WAIT, 32'h0);
    reg_check(icsp_pkg::REG_PROG_WAIT);
    reg_check(icsp_pkg::REG_ERASE_WAIT);
  endtask

  // Every plain command once, with a request dropped while busy
  task automatic test_each_command();
    logic [13:0] word;
    int          source;
    for (int c = icsp_pkg::CMD_LD_CFG; c <= icsp_pkg::CMD_ERASE2; c++) begin
      word   = (c == icsp_pkg::CMD_LD_CFG) ? WORD_ONES :
               (c == icsp_pkg::CMD_LD_PROG) ? 14'h0 : 14'($urandom_range(0, 16383));
      source = (c == icsp_pkg::CMD_RD_PROG) ? LEVEL_HIGH :
               (c == icsp_pkg::CMD_RD_USER) ? LEVEL_LOW : LEVEL_RAND;
      send_request(4'(c), word);
      repeat (3) send_tick(pick_level(source));
      send_request(4'($urandom_range(0, 15)), 14'($urandom_range(0, 16383)));
      run_to_idle(source);
    end
    settle();
  endtask

  // Short non-zero waits in begin and protected erase, run flat out
  task automatic test_short_waits();
    reg_write(icsp_pkg::REG_PROG_WAIT, 32'd1);
    reg_write(icsp_pkg::REG_ERASE_WAIT, 32'd3);
    idling_on = 1'b0;
    send_request(icsp_pkg::CMD_BEGIN, 14'($urandom_range(0, 16383)));
    run_to_idle(LEVEL_RAND);
    send_request(icsp_pkg::CMD_PROT_ERASE, 14'($urandom_range(0, 16383)));
    run_to_idle(LEVEL_RAND);
    settle();
    idling_on = 1'b1;
  endtask

  // Whole commands with random content, mixed with dropped requests and stray ticks
  task automatic test_random();
    int count;
    int r;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          reg_write(icsp_pkg::REG_PROG_WAIT, 32'd1);
          reg_write(icsp_pkg::REG_ERASE_WAIT, 32'd0);
        end
        1: begin
          reg_write(icsp_pkg::REG_PROG_WAIT, 32'd0);
          reg_write(icsp_pkg::REG_ERASE_WAIT, 32'd2);
        end
        default: begin
          reg_write(icsp_pkg::REG_PROG_WAIT, $urandom_range(0, 40));
          reg_write(icsp_pkg::REG_ERASE_WAIT, $urandom_range(0, 40));
        end
      endcase
      idling_on = (ph != 2);
      count = 0;
      while (count < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (cur_kind == icsp_pkg::KIND_IDLE) begin
          if (r < 80) begin
            send_request(4'($urandom_range(icsp_pkg::CMD_LD_CFG, icsp_pkg::CMD_PROT_ERASE)),
                         14'($urandom_range(0, 16383)));
            count++;
          end else if (r < 88) begin
            send_request(4'($urandom_range(icsp_pkg::CMD_PROT_ERASE + 1, 15)),
                         14'($urandom_range(0, 16383)));
            count++;
          end else begin
            send_tick(1'($urandom_range(0, 1)));
          end
        end else begin
          if (r < 95) send_tick(1'($urandom_range(0, 1)));
          else send_request(4'($urandom_range(0, 15)), 14'($urandom_range(0, 16383)));
          count++;
        end
      end
      run_to_idle(LEVEL_RAND);
      settle();
    end
    idling_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    in_valid <= 1'b0;
    in_item  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    rst_n    <= 1'b0;
    engine_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_idle_ticks();
    test_bad_codes();
    test_config_limits();
    test_each_command();
    test_short_waits();
    test_random();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pin_results_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
design/icsp_pkg.sv
design/icsp_cfg_regs.sv
design/icsp_core.sv
design/icsp_serial_command_engine.sv
design/icsp_checker.sv
verif/tb_icsp_serial_command_engine.sv
